FILE: sv/vdcm_pkg.sv
// Shared constants, codes and control types for the descriptor chain manager.
package vdcm_pkg;

	localparam int DESC_COUNT        = 8;
	localparam int IDX_W             = $clog2(DESC_COUNT);
	localparam int HEAD_W            = 4;
	localparam int SECTORS_PER_BLOCK = 2;
	localparam int BLOCK_W           = 32;
	localparam int SECTOR_W          = 33;
	localparam int AVAIL_W           = 16;
	localparam int FREED_W           = 4;

	localparam logic OP_SUBMIT  = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ERR_OK          = 2'd0,
		ERR_NO_DESC     = 2'd1,
		ERR_RANGE       = 2'd2,
		ERR_DOUBLE_FREE = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUB,
		S_WALK
	} state_t;

	typedef struct packed {
		logic load;
		logic sub_go;
		logic walk_go;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
	} status_t;

endpackage

FILE: sv/vdcm_ctrl.sv
// Controller state machine: input handshake, sequencing and result valid.
module vdcm_ctrl import vdcm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    opcode,
	output logic    out_valid,
	input  logic    out_stall,
	output cmd_t    cmd,
	input  status_t status
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   accept, out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		in_stall    = (state_q != S_IDLE);
		accept      = in_valid && !in_stall;
		// The result register can take a new result when empty or being drained.
		out_free    = !out_valid_q || !out_stall;
		cmd.load    = accept;
		cmd.sub_go  = 1'b0;
		cmd.walk_go = 1'b0;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (opcode == OP_RELEASE) ? S_WALK : S_SUB;
				end
			end
			S_SUB: begin
				if (out_free) begin
					cmd.sub_go = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_WALK: begin
				if (out_free) begin
					cmd.walk_go = 1'b1;
					if (status.walk_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (cmd.sub_go || (cmd.walk_go && status.walk_last)) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/vdcm_dpath.sv
// Datapath: descriptor table, free map, available index and result register.
module vdcm_dpath import vdcm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic [HEAD_W-1:0]   head_index,
	input  logic                write_request,
	input  logic [BLOCK_W-1:0]  block_number,
	output logic [1:0]          error_code,
	output logic [IDX_W-1:0]    head_out,
	output logic [IDX_W-1:0]    data_out,
	output logic [IDX_W-1:0]    status_out,
	output logic [IDX_W-1:0]    ring_slot,
	output logic [AVAIL_W-1:0]  avail_count,
	output logic [SECTOR_W-1:0] sector,
	output logic                req_type,
	output logic [FREED_W-1:0]  freed_count
);

	// Returns {found, index} of the lowest set bit.
	function automatic logic [IDX_W:0] find_low(input logic [DESC_COUNT-1:0] m);
		logic [IDX_W:0] r;
		r = '0;
		for (int i = DESC_COUNT - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = {1'b1, IDX_W'(i)};
			end
		end
		return r;
	endfunction

	logic [DESC_COUNT-1:0] free_map_q;
	logic [AVAIL_W-1:0]    avail_q;
	logic [IDX_W-1:0]      next_link_q [DESC_COUNT];
	logic                  has_next_q  [DESC_COUNT];

	logic [HEAD_W-1:0]     cur_q;
	logic [FREED_W-1:0]    freed_q;
	logic                  wr_q;
	logic [BLOCK_W-1:0]    blk_q;

	logic [1:0]            err_r_q;
	logic [IDX_W-1:0]      head_r_q, data_r_q, stat_r_q, slot_r_q;
	logic [AVAIL_W-1:0]    avail_r_q;
	logic [SECTOR_W-1:0]   sector_r_q;
	logic                  type_r_q;
	logic [FREED_W-1:0]    freed_r_q;

	logic [IDX_W:0]        f0, f1, f2;
	logic [DESC_COUNT-1:0] m1, m2;
	logic                  enough;
	logic [IDX_W-1:0]      cur_idx;
	logic                  cur_range_err, cur_dbl_err;
	logic [1:0]            walk_err;
	logic                  walk_free;

	always_comb begin
		f0     = find_low(free_map_q);
		m1     = free_map_q & ~(DESC_COUNT'(1) << f0[IDX_W-1:0]);
		f1     = find_low(m1);
		m2     = m1 & ~(DESC_COUNT'(1) << f1[IDX_W-1:0]);
		f2     = find_low(m2);
		enough = f0[IDX_W] && f1[IDX_W] && f2[IDX_W];

		cur_idx       = cur_q[IDX_W-1:0];
		cur_range_err = (cur_q >= HEAD_W'(DESC_COUNT));
		cur_dbl_err   = !cur_range_err && free_map_q[cur_idx];
		walk_free     = !cur_range_err && !cur_dbl_err;
		if (cur_range_err) begin
			walk_err = ERR_RANGE;
		end else if (cur_dbl_err) begin
			walk_err = ERR_DOUBLE_FREE;
		end else begin
			walk_err = ERR_OK;
		end
		// The walk ends on an error or at a descriptor without a next link.
		status.walk_last = !walk_free || !has_next_q[cur_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_map_q <= '1;
			avail_q    <= '0;
		end else if (cmd.sub_go && enough) begin
			free_map_q <= m2 & ~(DESC_COUNT'(1) << f2[IDX_W-1:0]);
			avail_q    <= avail_q + AVAIL_W'(1);
		end else if (cmd.walk_go && walk_free) begin
			free_map_q[cur_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sub_go && enough) begin
			has_next_q[f0[IDX_W-1:0]]  <= 1'b1;
			next_link_q[f0[IDX_W-1:0]] <= f1[IDX_W-1:0];
			has_next_q[f1[IDX_W-1:0]]  <= 1'b1;
			next_link_q[f1[IDX_W-1:0]] <= f2[IDX_W-1:0];
			has_next_q[f2[IDX_W-1:0]]  <= 1'b0;
			next_link_q[f2[IDX_W-1:0]] <= '0;
		end else if (cmd.walk_go && walk_free) begin
			has_next_q[cur_idx]  <= 1'b0;
			next_link_q[cur_idx] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q   <= head_index;
			freed_q <= '0;
			wr_q    <= write_request;
			blk_q   <= block_number;
		end else if (cmd.walk_go && walk_free) begin
			cur_q   <= {1'b0, next_link_q[cur_idx]};
			freed_q <= freed_q + FREED_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sub_go) begin
			err_r_q    <= enough ? ERR_OK : ERR_NO_DESC;
			head_r_q   <= enough ? f0[IDX_W-1:0] : '0;
			data_r_q   <= enough ? f1[IDX_W-1:0] : '0;
			stat_r_q   <= enough ? f2[IDX_W-1:0] : '0;
			slot_r_q   <= enough ? avail_q[IDX_W-1:0] : '0;
			avail_r_q  <= enough ? avail_q + AVAIL_W'(1) : '0;
			sector_r_q <= enough ? SECTOR_W'(blk_q) * SECTOR_W'(SECTORS_PER_BLOCK) : '0;
			type_r_q   <= enough ? wr_q : 1'b0;
			freed_r_q  <= '0;
		end else if (cmd.walk_go && status.walk_last) begin
			err_r_q    <= walk_err;
			head_r_q   <= '0;
			data_r_q   <= '0;
			stat_r_q   <= '0;
			slot_r_q   <= '0;
			avail_r_q  <= '0;
			sector_r_q <= '0;
			type_r_q   <= 1'b0;
			freed_r_q  <= walk_free ? freed_q + FREED_W'(1) : freed_q;
		end
	end

	assign error_code  = err_r_q;
	assign head_out    = head_r_q;
	assign data_out    = data_r_q;
	assign status_out  = stat_r_q;
	assign ring_slot   = slot_r_q;
	assign avail_count = avail_r_q;
	assign sector      = sector_r_q;
	assign req_type    = type_r_q;
	assign freed_count = freed_r_q;

endmodule

FILE: sv/virtq_descriptor_chain_manager.sv
// Top level of the split-queue descriptor chain manager.
// Each transfer in produces exactly one result transfer. A submit claims the three
// lowest free descriptors together, if three are free, and writes its result register
// in the submit state once that register is free; a release walks the chain one
// descriptor per cycle while the result register is free. The block takes one item
// at a time; a new item is taken as soon as the previous one has written its result
// register, even if that result has not yet been transferred out.
module virtq_descriptor_chain_manager import vdcm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [HEAD_W-1:0]   head_index,
	input  logic                write_request,
	input  logic [BLOCK_W-1:0]  block_number,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          error_code,
	output logic [IDX_W-1:0]    head_out,
	output logic [IDX_W-1:0]    data_out,
	output logic [IDX_W-1:0]    status_out,
	output logic [IDX_W-1:0]    ring_slot,
	output logic [AVAIL_W-1:0]  avail_count,
	output logic [SECTOR_W-1:0] sector,
	output logic                req_type,
	output logic [FREED_W-1:0]  freed_count
);

	cmd_t    cmd;
	status_t status;

	vdcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	vdcm_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.head_index    (head_index),
		.write_request (write_request),
		.block_number  (block_number),
		.error_code    (error_code),
		.head_out      (head_out),
		.data_out      (data_out),
		.status_out    (status_out),
		.ring_slot     (ring_slot),
		.avail_count   (avail_count),
		.sector        (sector),
		.req_type      (req_type),
		.freed_count   (freed_count)
	);

endmodule
